### design/color_code_text_scanner_defines.svh
// Assertion macros shared by the verification code of the color code text scanner.
`ifndef COLOR_CODE_TEXT_SCANNER_DEFINES_SVH
`define COLOR_CODE_TEXT_SCANNER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CCTS_ASSERT_SAME(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("ccts assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CCTS_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("ccts assertion failed");

`endif

### design/ccts_pkg.sv
`default_nettype none

package ccts_pkg;

   localparam int DATA_W              = 8;
   localparam int LIMIT_W             = 16;
   localparam int RESULT_W            = 16;
   localparam int COLOUR_W            = 12;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam logic [DATA_W-1:0]   CHAR_AMP       = 8'h26;
   localparam logic [DATA_W-1:0]   CHAR_C         = 8'h63;
   localparam logic [DATA_W-1:0]   CHAR_R         = 8'h72;
   localparam logic [COLOUR_W-1:0] COLOUR_DEFAULT = 12'hFFF;

   // Number of bytes held back for an escape that is still open.
   localparam logic [2:0] PEND_IDLE = 3'd0;
   localparam logic [2:0] PEND_AMP  = 3'd1;
   localparam logic [2:0] PEND_C    = 3'd2;
   localparam logic [2:0] PEND_D1   = 3'd3;
   localparam logic [2:0] PEND_D2   = 3'd4;

   typedef struct packed {
      logic [DATA_W-1:0]  data_byte;
      logic               end_marker;
      logic               limit_enable;
      logic [LIMIT_W-1:0] visible_limit;
   } req_item_type;

   typedef struct packed {
      logic [RESULT_W-1:0] visible_count;
      logic [RESULT_W-1:0] byte_offset;
      logic [COLOUR_W-1:0] last_colour;
   } rsp_item_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [DATA_W-1:0] ch);
      hex_type res;
      res.ok    = 1'b1;
      res.value = 4'd0;
      if (ch inside {[8'h30:8'h39]}) begin
         res.value = 4'(ch - 8'h30);
      end else if (ch inside {[8'h61:8'h66]}) begin
         res.value = 4'(ch - 8'h57);
      end else if (ch inside {[8'h41:8'h46]}) begin
         res.value = 4'(ch - 8'h37);
      end else begin
         res.ok = 1'b0;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### design/color_code_text_scanner.sv
// Color code text scanner.
// The request channel (req_valid, req_stall) brings one byte of text per
// request; a request with req_end_marker set closes the string, and its data
// byte is ignored. Limit inputs are sampled on every request. The response
// channel (rsp_valid, rsp_stall) returns one result per end marker: the
// visible character count, the byte offset consumed and the last color.
// While no end marker is held back, a request is taken in every cycle and the
// block sustains one byte per cycle. A request lands in the input register,
// then the scan stage updates its state and loads the output register.
// The single-pass scan stage handles any failed escape rescan (up to five
// visible bytes) in that one pass.
// A synchronous reset empties both registers and restores the scan state
// (counts zero, color 0x0fff). When the receiver stalls, a result waits in
// the output register; text bytes still flow, and only a following end
// marker waits in the input register, which then stalls the request side.
`default_nettype none

module color_code_text_scanner #(
   parameter int COUNT_WIDTH = ccts_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_marker,
   input  wire logic        req_limit_enable,
   input  wire logic [15:0] req_visible_limit,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_visible_count,
   output logic [15:0]      rsp_byte_offset,
   output logic [11:0]      rsp_last_colour
);
   import ccts_pkg::*;

   req_item_type req_item;
   req_item_type cur_item;
   rsp_item_type core_res;
   rsp_item_type rsp_item;
   logic         cur_vld;
   logic         advance;
   logic         res_load;

   assign req_item.data_byte     = req_data_byte;
   assign req_item.end_marker    = req_end_marker;
   assign req_item.limit_enable  = req_limit_enable;
   assign req_item.visible_limit = req_visible_limit;

   // Text bytes always move on; an end marker waits while a result is stuck.
   assign advance = cur_vld && !(cur_item.end_marker && rsp_valid && rsp_stall);

   ccts_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .advance   (advance),
      .req_stall (req_stall),
      .item_vld  (cur_vld),
      .item      (cur_item)
   );

   ccts_scan_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_scan_core (
      .clock     (clock),
      .reset     (reset),
      .item_fire (advance),
      .item      (cur_item),
      .res_load  (res_load),
      .res       (core_res)
   );

   ccts_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (res_load),
      .res       (core_res),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign rsp_visible_count = rsp_item.visible_count;
   assign rsp_byte_offset   = rsp_item.byte_offset;
   assign rsp_last_colour   = rsp_item.last_colour;

endmodule

`default_nettype wire

### design/ccts_in_reg.sv
`default_nettype none

module ccts_in_reg (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire ccts_pkg::req_item_type req_item,
   input  wire logic                   advance,
   output logic                        req_stall,
   output logic                        item_vld,
   output ccts_pkg::req_item_type      item
);
   import ccts_pkg::*;

   logic         vld_ff;
   logic         vld_in;
   req_item_type item_ff;

   // The register holds its request only while the scan stage cannot take it.
   assign req_stall = vld_ff && !advance;
   assign vld_in    = req_stall || req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         item_ff <= req_item;
      end
   end

   assign item_vld = vld_ff;
   assign item     = item_ff;

endmodule

`default_nettype wire

### design/ccts_scan_core.sv
`default_nettype none

module ccts_scan_core #(
   parameter int COUNT_WIDTH = ccts_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   item_fire,
   input  wire ccts_pkg::req_item_type item,
   output logic                        res_load,
   output ccts_pkg::rsp_item_type      res
);
   import ccts_pkg::*;

   localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
   localparam logic [COUNT_WIDTH-1:0] OUT_MAX = COUNT_WIDTH'(17'h0FFFF);

   logic [2:0]             pend_ff, pend_in;
   logic [11:0]            digits_ff, digits_in;
   logic [COUNT_WIDTH-1:0] vis_ff, vis_in;
   logic [COUNT_WIDTH-1:0] off_ff, off_in;
   logic [COLOUR_W-1:0]    colour_ff, colour_in;
   logic                   stopped_ff, stopped_in;

   logic [COUNT_WIDTH-1:0] vis_step [0:5];
   logic [5:0]             hit;
   logic [COUNT_WIDTH:0]   inc_sum;
   logic [COUNT_WIDTH:0]   off_sum;
   hex_type                hx;
   logic                   halt_now;
   logic                   fail;
   logic                   do_flush;
   logic                   hit_any;
   logic [2:0]             flush_cnt;
   logic [2:0]             take_cnt;
   logic [2:0]             off_add;

   // Candidate visible counts after zero to five more visible bytes, each
   // compared with the limit in parallel.
   always_comb begin
      inc_sum = '0;
      for (int j = 0; j < 6; j++) begin
         inc_sum     = {1'b0, vis_ff} + (COUNT_WIDTH + 1)'(j);
         vis_step[j] = inc_sum[COUNT_WIDTH] ? CNT_MAX : inc_sum[COUNT_WIDTH-1:0];
         hit[j]      = item.limit_enable &&
                       (CMP_W'(vis_step[j]) == CMP_W'(item.visible_limit));
      end
   end

   always_comb begin
      hx         = hex_decode(item.data_byte);
      halt_now   = stopped_ff || hit[0];
      pend_in    = PEND_IDLE;
      digits_in  = '0;
      colour_in  = colour_ff;
      stopped_in = stopped_ff;
      fail       = 1'b0;
      do_flush   = 1'b0;
      flush_cnt  = '0;
      off_add    = '0;
      hit_any    = 1'b0;

      if (halt_now) begin
         stopped_in = 1'b1;
      end else if (item.end_marker) begin
         // Held escape bytes become visible at the end of the string.
         do_flush  = 1'b1;
         flush_cnt = (pend_ff <= PEND_D2) ? pend_ff : PEND_IDLE;
      end else begin
         case (pend_ff)
            PEND_AMP: begin
               if (item.data_byte == CHAR_C) begin
                  pend_in = PEND_C;
               end else if (item.data_byte == CHAR_R) begin
                  off_add = 3'd2;
               end else begin
                  fail = 1'b1;
               end
            end
            PEND_C, PEND_D1: begin
               if (hx.ok) begin
                  pend_in   = pend_ff + 3'd1;
                  digits_in = {digits_ff[7:0], hx.value};
               end else begin
                  fail = 1'b1;
               end
            end
            PEND_D2: begin
               if (hx.ok) begin
                  colour_in = {digits_ff[7:0], hx.value};
                  off_add   = 3'd5;
               end else begin
                  fail = 1'b1;
               end
            end
            default: begin
               fail = 1'b1;
            end
         endcase
         if (fail) begin
            // Held bytes are rescanned as visible, then the new byte is
            // scanned afresh: visible unless it opens another escape.
            do_flush  = 1'b1;
            flush_cnt = ((pend_ff <= PEND_D2) ? pend_ff : PEND_IDLE) +
                        ((item.data_byte != CHAR_AMP) ? 3'd1 : 3'd0);
         end
      end

      // The first step that reaches the limit ends the flush.
      take_cnt = do_flush ? flush_cnt : 3'd0;
      if (do_flush) begin
         for (int j = 5; j >= 1; j--) begin
            if ((3'(j) <= flush_cnt) && hit[j]) begin
               take_cnt = 3'(j);
               hit_any  = 1'b1;
            end
         end
         off_add    = take_cnt;
         stopped_in = hit_any;
         if (fail && !hit_any && (item.data_byte == CHAR_AMP)) begin
            pend_in = PEND_AMP;
         end
      end

      vis_in  = vis_step[take_cnt];
      off_sum = {1'b0, off_ff} + (COUNT_WIDTH + 1)'(off_add);
      off_in  = off_sum[COUNT_WIDTH] ? CNT_MAX : off_sum[COUNT_WIDTH-1:0];
   end

   assign res_load          = item_fire && item.end_marker;
   assign res.visible_count = (vis_in > OUT_MAX) ? '1 : RESULT_W'(vis_in);
   assign res.byte_offset   = (off_in > OUT_MAX) ? '1 : RESULT_W'(off_in);
   assign res.last_colour   = colour_ff;

   always_ff @(posedge clock) begin
      if (reset || (item_fire && item.end_marker)) begin
         pend_ff    <= PEND_IDLE;
         digits_ff  <= '0;
         vis_ff     <= '0;
         off_ff     <= '0;
         colour_ff  <= COLOUR_DEFAULT;
         stopped_ff <= 1'b0;
      end else if (item_fire) begin
         pend_ff    <= pend_in;
         digits_ff  <= digits_in;
         vis_ff     <= vis_in;
         off_ff     <= off_in;
         colour_ff  <= colour_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

`default_nettype wire

### design/ccts_out_reg.sv
`default_nettype none

module ccts_out_reg (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire ccts_pkg::rsp_item_type res,
   input  wire logic                   rsp_stall,
   output logic                        rsp_valid,
   output ccts_pkg::rsp_item_type      rsp_item
);
   import ccts_pkg::*;

   logic         vld_ff;
   logic         vld_in;
   rsp_item_type item_ff;

   // A new result only arrives when the held one is gone or leaves now.
   assign vld_in = load || (vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= res;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_item  = item_ff;

endmodule

`default_nettype wire

### design/ccts_checker.sv
`default_nettype none
`include "color_code_text_scanner_defines.svh"

module ccts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_end_marker,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_visible_count,
   input wire logic [15:0] rsp_byte_offset,
   input wire logic [11:0] rsp_last_colour
);

   // A stalled result holds its value.
   `CCTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_visible_count) && $stable(rsp_byte_offset) && $stable(rsp_last_colour))

   // Reset empties the output register.
   `CCTS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // Every visible byte is also a consumed byte.
   `CCTS_ASSERT_SAME(a_count_le_offset, clock, reset, rsp_valid,
      rsp_visible_count <= rsp_byte_offset)

   // A fresh result follows an accepted end marker that passed the input register.
   `CCTS_ASSERT_SAME(a_rsp_from_end, clock, reset, $rose(rsp_valid),
      $past(req_valid && !req_stall && req_end_marker, 2))

endmodule

bind color_code_text_scanner ccts_checker u_ccts_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_end_marker    (req_end_marker),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_visible_count (rsp_visible_count),
   .rsp_byte_offset   (rsp_byte_offset),
   .rsp_last_colour   (rsp_last_colour)
);

`default_nettype wire

### tb/tb_color_code_text_scanner.sv
`default_nettype none

// Self-checking bench for the color code text scanner.
// Text strings are queued up front by the stimulus process. A clocked driver
// offers them one request at a time, and a clocked monitor checks each result
// against the totals that a scan model in this file works out as the requests
// are accepted.
module tb_color_code_text_scanner;
   import ccts_pkg::*;

   // One entry of the request feed. An entry with the drain flag set is not
   // sent. It holds the sender back until every result that is owed has come.
   typedef struct {
      req_item_type req;
      bit           drain;
   } feed_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_marker = 1'b0;
   logic        req_limit_enable = 1'b0;
   logic [15:0] req_visible_limit = 16'h0000;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_visible_count;
   logic [15:0] rsp_byte_offset;
   logic [11:0] rsp_last_colour;

   feed_item_type byte_feed[$];   // requests still to be offered
   rsp_item_type  due_totals[$];  // totals owed by the block, oldest first

   int unsigned req_count = 0;
   int unsigned string_count = 0;
   int unsigned fault_count = 0;
   int          tx_idle_pct;
   int          rx_idle_pct;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;

   // Limit settings used while a string is being built.
   bit          str_lim_en = 1'b0;
   logic [15:0] str_lim = 16'h0000;
   bit          jitter_on = 1'b0;

   // Scan model state. The counters saturate at the 16-bit maximum, which
   // matches the block's default counter width.
   int unsigned seen_visible;
   int unsigned seen_offset;
   logic [2:0]  held_bytes;
   logic [11:0] held_digits;
   logic [11:0] scan_colour;
   bit          scan_halted;
   bit          cur_limit_en;
   int unsigned cur_limit;

   color_code_text_scanner u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_marker    (req_end_marker),
      .req_limit_enable  (req_limit_enable),
      .req_visible_limit (req_visible_limit),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_visible_count (rsp_visible_count),
      .rsp_byte_offset   (rsp_byte_offset),
      .rsp_last_colour   (rsp_last_colour)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs. It sits far above the slowest
   // legal run, even with the lazy receiver and the long hold-off.
   initial begin
      #2_000_000;
      $display("color_code_text_scanner: mismatch");
      $finish;
   end

   // ------------------------------------------------------------------
   // Scan model
   // ------------------------------------------------------------------

   function automatic int unsigned sat16(input int unsigned a, input int unsigned b);
      return (a + b > 65535) ? 65535 : a + b;
   endfunction

   // Value of a hex digit in either case, or -1 for anything else.
   function automatic int hex_value(input logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return int'(ch - "0");
      if (ch >= "a" && ch <= "f") return int'(ch - "a") + 10;
      if (ch >= "A" && ch <= "F") return int'(ch - "A") + 10;
      return -1;
   endfunction

   function void clear_scan();
      seen_visible = 0;
      seen_offset  = 0;
      held_bytes   = PEND_IDLE;
      held_digits  = '0;
      scan_colour  = COLOUR_DEFAULT;
      scan_halted  = 1'b0;
   endfunction

   // The stop condition is sticky: once the count has met the limit, the
   // rest of the string is dropped, even if the limit inputs change later.
   function bit limit_hit();
      if (!scan_halted && cur_limit_en && seen_visible == cur_limit) scan_halted = 1'b1;
      return scan_halted;
   endfunction

   function void count_visible();
      if (limit_hit()) return;
      seen_visible = sat16(seen_visible, 1);
      seen_offset  = sat16(seen_offset, 1);
      void'(limit_hit());
   endfunction

   // A failed escape gives back its held bytes as visible characters, one
   // at a time, so the limit can cut the rescan short.
   function void release_held();
      int n;
      n = int'(held_bytes);
      held_bytes  = PEND_IDLE;
      held_digits = '0;
      repeat (n) count_visible();
   endfunction

   function void scan_fresh(input logic [7:0] ch);
      if (limit_hit()) return;
      if (ch == CHAR_AMP) held_bytes = PEND_AMP;
      else count_visible();
   endfunction

   function void scan_text(input logic [7:0] ch);
      int nib;
      nib = hex_value(ch);
      if (limit_hit()) begin
         held_bytes  = PEND_IDLE;
         held_digits = '0;
         return;
      end
      case (held_bytes)
         PEND_AMP: begin
            if (ch == CHAR_C) begin
               held_bytes = PEND_C;
            end else if (ch == CHAR_R) begin
               held_bytes  = PEND_IDLE;
               seen_offset = sat16(seen_offset, 2);
            end else begin
               release_held();
               scan_fresh(ch);
            end
         end
         PEND_C, PEND_D1: begin
            if (nib >= 0) begin
               held_digits = {held_digits[7:0], 4'(nib)};
               held_bytes  = held_bytes + 3'd1;
            end else begin
               release_held();
               scan_fresh(ch);
            end
         end
         PEND_D2: begin
            if (nib >= 0) begin
               scan_colour = {held_digits[7:0], 4'(nib)};
               held_bytes  = PEND_IDLE;
               held_digits = '0;
               seen_offset = sat16(seen_offset, 5);
            end else begin
               release_held();
               scan_fresh(ch);
            end
         end
         default: begin
            held_bytes  = PEND_IDLE;
            held_digits = '0;
            scan_fresh(ch);
         end
      endcase
   endfunction

   // Applies one accepted request. An end marker flushes any open escape,
   // queues the totals the block owes and starts a new string.
   function void scan_request(input req_item_type r);
      rsp_item_type totals;
      cur_limit_en = r.limit_enable;
      cur_limit    = 32'(r.visible_limit);
      if (!r.end_marker) begin
         scan_text(r.data_byte);
         return;
      end
      if (!limit_hit()) release_held();
      totals.visible_count = 16'(seen_visible);
      totals.byte_offset   = 16'(seen_offset);
      totals.last_colour   = scan_colour;
      due_totals.push_back(totals);
      clear_scan();
   endfunction

   function void report_fault(input string what, input int unsigned want, input int unsigned got);
      fault_count++;
      if (fault_count <= 10)
         $display("ERROR at %0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
   endfunction

   // ------------------------------------------------------------------
   // Idling: the first third of the traffic has a lazy receiver, the
   // second a lazy sender, and the rest runs with neither side idling.
   // ------------------------------------------------------------------
   always_comb begin
      if (req_count < 350) begin
         tx_idle_pct = 14;
         rx_idle_pct = 84;
      end else if (req_count < 700) begin
         tx_idle_pct = 84;
         rx_idle_pct = 14;
      end else begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end
   end

   // Long receiver hold-off. Once it starts, the receiver refuses results until
   // the hold-off counter runs out while the sender keeps going, so a finished result
   // and then an end marker back up inside the block and stall the requests.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && req_count >= 250) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Driver. A request is accepted at an edge with valid high and stall
   // low; it goes into the scan model right there. A stalled request is held
   // unchanged. Otherwise the next one from the feed is offered, unless this
   // cycle is picked as idle or a drain entry is waiting on the results.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : driver
      feed_item_type nxt;
      bit            can_go;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            scan_request('{data_byte: req_data_byte, end_marker: req_end_marker,
                           limit_enable: req_limit_enable,
                           visible_limit: req_visible_limit});
            req_count <= req_count + 1;
         end
         if (!(req_valid && req_stall)) begin
            can_go = byte_feed.size() != 0 && ($urandom_range(99) >= tx_idle_pct);
            if (can_go && byte_feed[0].drain) begin
               can_go = 1'b0;
               if (due_totals.size() == 0) void'(byte_feed.pop_front());
            end
            if (can_go) begin
               nxt = byte_feed.pop_front();
               req_valid         <= 1'b1;
               req_data_byte     <= nxt.req.data_byte;
               req_end_marker    <= nxt.req.end_marker;
               req_limit_enable  <= nxt.req.limit_enable;
               req_visible_limit <= nxt.req.visible_limit;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor. Drives the result stall and checks every accepted result,
   // field by field, against the oldest totals still owed.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < rx_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (due_totals.size() == 0) begin
               report_fault("unrequested result, visible_count", 0,
                            32'(rsp_visible_count));
            end else begin
               want = due_totals.pop_front();
               string_count++;
               if (rsp_visible_count != want.visible_count)
                  report_fault("visible_count", 32'(want.visible_count),
                               32'(rsp_visible_count));
               if (rsp_byte_offset != want.byte_offset)
                  report_fault("byte_offset", 32'(want.byte_offset), 32'(rsp_byte_offset));
               if (rsp_last_colour != want.last_colour)
                  report_fault("last_colour", 32'(want.last_colour), 32'(rsp_last_colour));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------

   // Queues one text byte. With jitter on, a few bytes carry limit inputs
   // of their own even though the string should keep them steady.
   task automatic add_byte(input logic [7:0] ch);
      feed_item_type it;
      it.drain              = 1'b0;
      it.req.data_byte      = ch;
      it.req.end_marker     = 1'b0;
      it.req.limit_enable   = str_lim_en;
      it.req.visible_limit  = str_lim;
      if (jitter_on && $urandom_range(24) == 0) begin
         it.req.limit_enable  = 1'($urandom_range(1));
         it.req.visible_limit = 16'($urandom_range(65535));
      end
      byte_feed.push_back(it);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   // The end marker's data byte is random, since the block must ignore it.
   task automatic add_end();
      feed_item_type it;
      it.drain             = 1'b0;
      it.req.data_byte     = 8'($urandom_range(255));
      it.req.end_marker    = 1'b1;
      it.req.limit_enable  = str_lim_en;
      it.req.visible_limit = str_lim;
      byte_feed.push_back(it);
   endtask

   task automatic add_drain();
      feed_item_type it;
      it.drain = 1'b1;
      it.req   = '0;
      byte_feed.push_back(it);
   endtask

   function automatic logic [7:0] hex_char();
      int v;
      v = $urandom_range(21);
      if (v < 10) return 8'("0" + v);
      if (v < 16) return 8'("a" + v - 10);
      return 8'("A" + v - 16);
   endfunction

   // A random string built mostly from well-formed pieces: plain bytes,
   // resets, full color escapes, and escapes broken at every position,
   // some of them left open right before the end marker.
   task automatic add_random_string();
      int tokens;
      int pick;
      int k;
      str_lim_en = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 55) str_lim = 16'($urandom_range(12));
      else if (pick < 85) str_lim = 16'($urandom_range(65535));
      else str_lim = pick[0] ? 16'hFFFF : 16'h0000;
      tokens = ($urandom_range(19) == 0) ? $urandom_range(60, 30) : $urandom_range(8);
      repeat (tokens) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            add_byte(8'($urandom_range(255)));
         end else if (pick < 60) begin
            add_byte(CHAR_AMP);
            add_byte(CHAR_R);
         end else if (pick < 80) begin
            add_byte(CHAR_AMP);
            add_byte(CHAR_C);
            repeat (3) add_byte(hex_char());
         end else begin
            add_byte(CHAR_AMP);
            k = $urandom_range(3);
            if (k >= 1) add_byte(CHAR_C);
            for (int i = 1; i < k; i++) add_byte(hex_char());
            if (pick < 95) add_byte(8'($urandom_range(255)));
         end
      end
      add_end();
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      clear_scan();
      cur_limit_en = 1'b0;
      cur_limit    = 0;

      // Directed strings. Uppercase hex with a zero byte after the escape; a
      // lowercase escape broken on its last digit by an all-ones byte; a doubled
      // ampersand in front of a reset; a zero limit that stops the scan before
      // the first byte; an open escape at the end marker that is rescanned
      // under a limit; and an empty string.
      str_lim_en = 1'b0;
      str_lim    = 16'h0000;
      add_text("&c09F");
      add_byte(8'h00);
      add_end();
      add_text("&caf");
      add_byte(8'hFF);
      add_end();
      add_text("&&r");
      add_end();
      str_lim_en = 1'b1;
      str_lim    = 16'd0;
      add_text("ab");
      add_end();
      str_lim = 16'd2;
      add_text("&c1");
      add_end();
      str_lim_en = 1'b0;
      str_lim    = 16'hFFFF;
      add_end();

      // Random strings, with a pause halfway through in which the sender
      // waits for every owed result before going on.
      jitter_on = 1'b1;
      while (byte_feed.size() < 520) add_random_string();
      add_drain();
      while (byte_feed.size() < 1025) add_random_string();
      jitter_on = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (byte_feed.size() != 0 || req_valid || due_totals.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Run summary: %0d requests accepted, %0d strings checked.", req_count,
               string_count);
      $display("Covered escapes, broken escapes, limits, stalls and a full drain.");
      if (fault_count == 0) begin
         $display("color_code_text_scanner: match");
      end else begin
         $display("%0d field errors found.", fault_count);
         $display("color_code_text_scanner: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
